### src/att_pkg.sv
// Shared constants, codes and address helpers for the ANSI text terminal core.
// No dependencies; imported by ansi_text_terminal_core and its testbench.
`default_nettype none

package att_pkg;

  // screen geometry
  localparam int ROWS   = 24;
  localparam int COLS   = 80;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CHAR_W = 7;
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ARG_W  = 8;
  localparam int ARG_MAX = 255;

  // request operations
  localparam logic OP_FEED = 1'b0;
  localparam logic OP_READ = 1'b1;

  // parser modes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_ESCAPE = 2'd1;
  localparam logic [1:0] MODE_CSI    = 2'd2;

  // byte codes
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP    = 8'h41;
  localparam logic [7:0] CH_DOWN  = 8'h42;
  localparam logic [7:0] CH_RIGHT = 8'h43;
  localparam logic [7:0] CH_LEFT  = 8'h44;
  localparam logic [7:0] CH_HOME  = 8'h48;
  localparam logic [7:0] CH_ED    = 8'h4A;
  localparam logic [7:0] CH_EL    = 8'h4B;

  localparam logic [CHAR_W-1:0] BLANK = CHAR_W'(CH_SPACE);

  // logical row -> physical row, the screen is a ring of rows starting at top
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lr,
                                                input logic [ROW_W-1:0] top);
    logic [ROW_W:0] sum;
    sum = {1'b0, lr} + {1'b0, top};
    if (sum >= (ROW_W+1)'(ROWS)) sum = sum - (ROW_W+1)'(ROWS);
    return sum[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] pr,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(ADDR_W'(pr) * ADDR_W'(COLS)) + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

### src/att_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module att_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/ansi_text_terminal_core.sv
// ANSI text terminal core: 24x80 screen in one RAM, cursor, escape parser.
// Depends on att_pkg and att_ram.
`default_nettype none

// Each request is either a byte fed to the terminal or a read of one screen
// cell; every request gives exactly one result. One request is in work at a
// time. A plain byte is decoded and its cell written on acceptance, then its
// result is staged; a cell read waits on the registered RAM read before
// staging. Work that blanks cells goes through the single RAM write port one
// cell per cycle: a scroll blanks COLS (80) cells, ESC[K COLS-col cells and
// ESC[J up to ROWS*COLS (1920). Scrolling moves a row-ring pointer, no rows
// are copied. After reset a clearing pass blanks all ROWS*COLS (1920) cells,
// with in_ready low until it ends.

module ansi_text_terminal_core
  import att_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_operation,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic [ROW_W-1:0]  in_read_row,
  input  wire logic [COL_W-1:0]  in_read_col,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_beep,
  output logic      [CHAR_W-1:0] out_cell_char,
  output logic                   out_cell_is_cursor,
  output logic      [ROW_W-1:0]  out_cursor_row_out,
  output logic      [COL_W-1:0]  out_cursor_col_out
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [ROW_W-1:0] cur_row_r, cur_row_nxt;
  logic [COL_W-1:0] cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0] top_r, top_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic [ARG_W-1:0] argc_r, argc_nxt;
  logic [ARG_W-1:0] argp_r, argp_nxt;

  // blanking sweep
  logic [ROW_W-1:0] sw_row_r;
  logic [COL_W-1:0] sw_col_r;
  logic             sw_multi_r;
  logic             sw_init_r;
  logic             sweep_go;
  logic [ROW_W-1:0] sweep_row;
  logic [COL_W-1:0] sweep_col;
  logic             sweep_multi;
  logic             sweep_done;

  // result staging
  logic              res_beep_r, beep_nxt;
  logic [CHAR_W-1:0] res_char_r;
  logic              res_cur_r;
  logic              rd_oor_r;

  logic              accept, is_feed, is_read, out_free;
  logic              wr_char, do_lf, rd_oor;
  logic [7:0]        b;
  logic [ARG_W-1:0]  n, m, hc, hr;
  logic [11:0]       prod;
  logic [ARG_W:0]    sum9;
  logic [7:0]        tab;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CHAR_W-1:0] mem_wdata, mem_rdata;

  assign in_ready   = (state_r == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign is_feed    = accept && (in_operation == OP_FEED);
  assign is_read    = accept && (in_operation == OP_READ);
  assign out_free   = !out_valid || out_ready;
  assign b          = in_data_byte;
  assign sweep_done = (sw_col_r == COL_W'(COLS - 1)) &&
                      (!sw_multi_r || sw_row_r == ROW_W'(ROWS - 1));

  assign rd_oor = (in_read_row >= ROW_W'(ROWS)) || (in_read_col >= COL_W'(COLS));

  // memory ports
  assign mem_we    = (state_r == ST_SWEEP) || (is_feed && wr_char);
  assign mem_waddr = (state_r == ST_SWEEP) ? cell_addr(phys_row(sw_row_r, top_r), sw_col_r)
                                           : cell_addr(phys_row(cur_row_r, top_r), cur_col_r);
  assign mem_wdata = (state_r == ST_SWEEP) ? BLANK : b[CHAR_W-1:0];
  assign mem_re    = is_read && !rd_oor;
  assign mem_raddr = cell_addr(phys_row(in_read_row, top_r), in_read_col);

  att_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // byte decode: cursor, parser and scroll
  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    top_nxt     = top_r;
    mode_nxt    = mode_r;
    argc_nxt    = argc_r;
    argp_nxt    = argp_r;
    beep_nxt    = 1'b0;
    wr_char     = 1'b0;
    do_lf       = 1'b0;
    sweep_go    = 1'b0;
    sweep_row   = cur_row_r;
    sweep_col   = cur_col_r;
    sweep_multi = 1'b0;

    n    = (argc_r == '0) ? ARG_W'(1) : argc_r;
    m    = (argp_r == '0) ? ARG_W'(1) : argp_r;
    hc   = (n > ARG_W'(COLS)) ? ARG_W'(COLS) : n;
    hr   = (m > ARG_W'(ROWS)) ? ARG_W'(ROWS) : m;
    prod = ({4'b0, argc_r} << 3) + ({4'b0, argc_r} << 1) + {8'b0, b[3:0]};
    sum9 = '0;
    tab  = ({1'b0, cur_col_r} + 8'd8) & ~8'd7;

    if (mode_r == MODE_ESCAPE) begin
      if (b == CH_LBRK) begin
        mode_nxt = MODE_CSI;
        argc_nxt = '0;
        argp_nxt = '0;
      end else begin
        mode_nxt = MODE_NORMAL;
      end
    end else if (mode_r == MODE_CSI) begin
      if (b >= CH_ZERO && b <= CH_NINE) begin
        argc_nxt = (prod > 12'(ARG_MAX)) ? ARG_W'(ARG_MAX) : prod[ARG_W-1:0];
      end else if (b == CH_SEMI) begin
        argp_nxt = argc_r;
        argc_nxt = '0;
      end else begin
        mode_nxt = MODE_NORMAL;
        case (b)
          CH_UP: begin
            cur_row_nxt = (n > ARG_W'(cur_row_r)) ? '0 : cur_row_r - n[ROW_W-1:0];
          end
          CH_DOWN: begin
            sum9 = {1'b0, n} + (ARG_W+1)'(cur_row_r);
            cur_row_nxt = (sum9 > (ARG_W+1)'(ROWS - 1)) ? ROW_W'(ROWS - 1)
                                                         : sum9[ROW_W-1:0];
          end
          CH_RIGHT: begin
            sum9 = {1'b0, n} + (ARG_W+1)'(cur_col_r);
            cur_col_nxt = (sum9 > (ARG_W+1)'(COLS - 1)) ? COL_W'(COLS - 1)
                                                         : sum9[COL_W-1:0];
          end
          CH_LEFT: begin
            cur_col_nxt = (n > ARG_W'(cur_col_r)) ? '0 : cur_col_r - n[COL_W-1:0];
          end
          CH_HOME: begin
            cur_col_nxt = COL_W'(hc - ARG_W'(1));
            cur_row_nxt = ROW_W'(hr - ARG_W'(1));
          end
          CH_ED: begin
            sweep_go    = 1'b1;
            sweep_multi = 1'b1;
          end
          CH_EL: begin
            sweep_go = 1'b1;
          end
          default: ;
        endcase
      end
    end else begin
      mode_nxt = MODE_NORMAL;
      if (b < CH_SPACE) begin
        case (b)
          CH_BEL: beep_nxt = 1'b1;
          CH_BS:  if (cur_col_r != '0) cur_col_nxt = cur_col_r - COL_W'(1);
          CH_TAB: cur_col_nxt = (tab > 8'(COLS - 1)) ? COL_W'(COLS - 1) : tab[COL_W-1:0];
          CH_LF:  do_lf = 1'b1;
          CH_CR:  cur_col_nxt = '0;
          CH_ESC: mode_nxt = MODE_ESCAPE;
          default: ;
        endcase
      end else if (b < CH_DEL) begin
        wr_char = 1'b1;
        if (cur_col_r == COL_W'(COLS - 1)) begin
          cur_col_nxt = '0;
          do_lf       = 1'b1;
        end else begin
          cur_col_nxt = cur_col_r + COL_W'(1);
        end
      end
    end

    if (do_lf) begin
      if (cur_row_r == ROW_W'(ROWS - 1)) begin
        // scroll: rotate the row ring, the old top row becomes the blank bottom
        top_nxt     = (top_r == ROW_W'(ROWS - 1)) ? '0 : top_r + ROW_W'(1);
        sweep_go    = 1'b1;
        sweep_row   = ROW_W'(ROWS - 1);
        sweep_col   = '0;
        sweep_multi = 1'b0;
      end else begin
        cur_row_nxt = cur_row_r + ROW_W'(1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (is_read)       state_nxt = ST_READ;
        else if (is_feed)  state_nxt = sweep_go ? ST_SWEEP : ST_FIN;
      end
      ST_READ:  state_nxt = ST_FIN;
      ST_SWEEP: if (sweep_done) state_nxt = sw_init_r ? ST_IDLE : ST_FIN;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_SWEEP;
      cur_row_r  <= '0;
      cur_col_r  <= '0;
      top_r      <= '0;
      mode_r     <= MODE_NORMAL;
      argc_r     <= '0;
      argp_r     <= '0;
      sw_row_r   <= '0;
      sw_col_r   <= '0;
      sw_multi_r <= 1'b1;
      sw_init_r  <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (is_feed) begin
        cur_row_r <= cur_row_nxt;
        cur_col_r <= cur_col_nxt;
        top_r     <= top_nxt;
        mode_r    <= mode_nxt;
        argc_r    <= argc_nxt;
        argp_r    <= argp_nxt;
        if (sweep_go) begin
          sw_row_r   <= sweep_row;
          sw_col_r   <= sweep_col;
          sw_multi_r <= sweep_multi;
          sw_init_r  <= 1'b0;
        end
      end else if (state_r == ST_SWEEP) begin
        if (sw_col_r == COL_W'(COLS - 1)) begin
          sw_col_r <= '0;
          sw_row_r <= sw_row_r + ROW_W'(1);
        end else begin
          sw_col_r <= sw_col_r + COL_W'(1);
        end
      end
      if (state_r == ST_FIN && out_free) out_valid <= 1'b1;
      else if (out_ready)                out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_feed) begin
      res_beep_r <= beep_nxt;
      res_char_r <= '0;
      res_cur_r  <= 1'b0;
    end else if (is_read) begin
      res_beep_r <= 1'b0;
      res_cur_r  <= !rd_oor && (in_read_row == cur_row_r) && (in_read_col == cur_col_r);
      rd_oor_r   <= rd_oor;
    end
    if (state_r == ST_READ) res_char_r <= rd_oor_r ? '0 : mem_rdata;
    if (state_r == ST_FIN && out_free) begin
      out_beep           <= res_beep_r;
      out_cell_char      <= res_char_r;
      out_cell_is_cursor <= res_cur_r;
      out_cursor_row_out <= cur_row_r;
      out_cursor_col_out <= cur_col_r;
    end
  end

  // cursor and ring pointer stay on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_row_r < ROW_W'(ROWS)) && (cur_col_r < COL_W'(COLS)) && (top_r < ROW_W'(ROWS)))
    else $error("cursor or row ring pointer off screen");

  // an accepted read goes to the RAM-wait state
  a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
    is_read |=> (state_r == ST_READ))
    else $error("read request did not wait on RAM data");

  // the RAM is written only by a sweep or by a fed printable byte
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((state_r == ST_SWEEP) || (is_feed && mode_r == MODE_NORMAL)))
    else $error("unexpected screen write");

  // a result is only loaded into a free output register
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid && !out_ready) |=> (state_r == ST_FIN))
    else $error("result left staging while output was full");

endmodule

`default_nettype wire

### tb/sv/tb_ansi_text_terminal_core.sv
`timescale 1ns / 1ps
// Testbench for ansi_text_terminal_core: byte feeds and cell reads checked
// against a cycle-free screen/cursor/parser predictor. Depends on att_pkg.

module tb_ansi_text_terminal_core;
  import att_pkg::*;

  localparam int STIM_ITEMS   = 1975;
  localparam int DRAIN_EVERY  = 400;
  localparam int STALL_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 2000;

  typedef struct packed {
    logic              op;
    logic [7:0]        data;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    bit                aim;    // read the cell under the cursor, resolved at send time
    bit                drain;  // hold off until every result is back
  } term_req_t;

  typedef struct packed {
    logic              beep;
    logic [CHAR_W-1:0] cell_char;
    logic              cell_is_cursor;
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
  } term_resp_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_operation = OP_FEED;
  logic [7:0]        in_data_byte = 8'h00;
  logic [ROW_W-1:0]  in_read_row = '0;
  logic [COL_W-1:0]  in_read_col = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_beep;
  logic [CHAR_W-1:0] out_cell_char;
  logic              out_cell_is_cursor;
  logic [ROW_W-1:0]  out_cursor_row_out;
  logic [COL_W-1:0]  out_cursor_col_out;

  term_req_t  pending_reqs[$];
  term_resp_t predicted_resp[$];

  // terminal shadow state
  logic [CHAR_W-1:0] screen_mem [CELLS];
  int                scr_row = 0;
  int                scr_col = 0;
  logic [1:0]        parse_mode = MODE_NORMAL;
  int                arg_now = 0;
  int                arg_prev = 0;

  bit  req_taken = 1'b0;
  bit  drain_next = 1'b0;
  int  send_gap = 0;
  int  stall_cnt = 0;
  int  fault_cnt = 0;
  int  idle_cycles = 0;
  int  cycle_cnt = 0;

  always #5 clk = ~clk;

  ansi_text_terminal_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_data_byte       (in_data_byte),
    .in_read_row        (in_read_row),
    .in_read_col        (in_read_col),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_beep           (out_beep),
    .out_cell_char      (out_cell_char),
    .out_cell_is_cursor (out_cell_is_cursor),
    .out_cursor_row_out (out_cursor_row_out),
    .out_cursor_col_out (out_cursor_col_out)
  );

  // ---------------------------------------------------------------- predictor

  function automatic void blank_span(input int row, input int from_col);
    for (int c = from_col; c < COLS; c++)
      screen_mem[row * COLS + c] = BLANK;
  endfunction

  function automatic void line_down();
    scr_row++;
    if (scr_row >= ROWS) begin
      for (int i = 0; i < (ROWS - 1) * COLS; i++)
        screen_mem[i] = screen_mem[i + COLS];
      blank_span(ROWS - 1, 0);
      scr_row = ROWS - 1;
    end
  endfunction

  // updates the shadow terminal with one byte, returns the beep flag
  function automatic logic term_feed(input logic [7:0] b);
    int   n;
    int   m;
    logic beep;
    beep = 1'b0;
    case (parse_mode)
      MODE_ESCAPE: begin
        if (b == CH_LBRK) begin
          parse_mode = MODE_CSI;
          arg_now = 0;
          arg_prev = 0;
        end else begin
          parse_mode = MODE_NORMAL;
        end
      end
      MODE_CSI: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          arg_now = arg_now * 10 + int'(b - CH_ZERO);
          if (arg_now > ARG_MAX) arg_now = ARG_MAX;
        end else if (b == CH_SEMI) begin
          arg_prev = arg_now;
          arg_now = 0;
        end else begin
          n = (arg_now == 0) ? 1 : arg_now;
          m = (arg_prev == 0) ? 1 : arg_prev;
          case (b)
            CH_UP:    scr_row = (n > scr_row) ? 0 : scr_row - n;
            CH_DOWN:  scr_row = (scr_row + n > ROWS - 1) ? ROWS - 1 : scr_row + n;
            CH_RIGHT: scr_col = (scr_col + n > COLS - 1) ? COLS - 1 : scr_col + n;
            CH_LEFT:  scr_col = (n > scr_col) ? 0 : scr_col - n;
            CH_HOME: begin
              if (n > COLS) n = COLS;
              if (m > ROWS) m = ROWS;
              scr_col = n - 1;
              scr_row = m - 1;
            end
            CH_ED: begin
              blank_span(scr_row, scr_col);
              for (int r = scr_row + 1; r < ROWS; r++)
                blank_span(r, 0);
            end
            CH_EL: blank_span(scr_row, scr_col);
            default: ;
          endcase
          parse_mode = MODE_NORMAL;
        end
      end
      default: begin
        parse_mode = MODE_NORMAL;
        if (b < CH_SPACE) begin
          case (b)
            CH_BEL: beep = 1'b1;
            CH_BS:  if (scr_col > 0) scr_col--;
            CH_TAB: begin
              scr_col = (scr_col + 8) & ~7;
              if (scr_col > COLS - 1) scr_col = COLS - 1;
            end
            CH_LF:  line_down();
            CH_CR:  scr_col = 0;
            CH_ESC: parse_mode = MODE_ESCAPE;
            default: ;
          endcase
        end else if (b < CH_DEL) begin
          screen_mem[scr_row * COLS + scr_col] = b[CHAR_W-1:0];
          scr_col++;
          if (scr_col >= COLS) begin
            scr_col = 0;
            line_down();
          end
        end
      end
    endcase
    return beep;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic int pick_gap();
    int r;
    if (((cycle_cnt / 3000) % 4) == 3) return 0;  // quiet stretch, no idling
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_req(input logic op, input logic [7:0] data,
                         input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                         input bit aim);
    term_req_t req;
    req.op = op;
    req.data = data;
    req.row = row;
    req.col = col;
    req.aim = aim;
    req.drain = drain_next;
    drain_next = 1'b0;
    pending_reqs.push_back(req);
  endtask

  task automatic add_feed(input logic [7:0] b);
    add_req(OP_FEED, b, ROW_W'($urandom), COL_W'($urandom), 1'b0);
  endtask

  task automatic add_read(input int row, input int col);
    add_req(OP_READ, 8'($urandom), ROW_W'(row), COL_W'(col), 1'b0);
  endtask

  task automatic add_cursor_read();
    add_req(OP_READ, 8'($urandom), ROW_W'($urandom), COL_W'($urandom), 1'b1);
  endtask

  // ---------------------------------------------------------------- driver

  always @(negedge clk) begin : driver
    term_req_t req;
    logic      nxt_valid;
    if (rst_n) begin
      nxt_valid = in_valid;
      if (!in_valid || req_taken) begin
        req_taken = 1'b0;
        nxt_valid = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reqs.size() > 0) begin
          req = pending_reqs[0];
          if (!(req.drain && predicted_resp.size() != 0)) begin
            req = pending_reqs.pop_front();
            if (req.aim) begin
              req.row = ROW_W'(scr_row);
              req.col = COL_W'(scr_col);
            end
            in_operation <= req.op;
            in_data_byte <= req.data;
            in_read_row  <= req.row;
            in_read_col  <= req.col;
            nxt_valid = 1'b1;
            send_gap = pick_gap();
          end
        end
      end
      in_valid <= nxt_valid;
    end
  end

  always @(negedge clk) begin : receiver
    if (stall_cnt > 0) begin
      stall_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_cnt = pick_gap();
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : monitor
    term_resp_t got;
    term_resp_t want;
    bit         progress;
    cycle_cnt++;
    if (rst_n) begin
      progress = 1'b0;
      if (out_valid && out_ready) begin
        progress = 1'b1;
        got = {out_beep, out_cell_char, out_cell_is_cursor,
               out_cursor_row_out, out_cursor_col_out};
        if (predicted_resp.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= 10)
            $display("%0t: result with no request pending: beep=%0d char=%02h cur=%0d row=%0d col=%0d",
                     $realtime, got.beep, got.cell_char, got.cell_is_cursor,
                     got.cur_row, got.cur_col);
        end else begin
          want = predicted_resp.pop_front();
          if (got !== want) begin
            fault_cnt++;
            if (fault_cnt <= 10)
              $display("%0t: mismatch exp beep=%0d char=%02h cur=%0d row=%0d col=%0d, got beep=%0d char=%02h cur=%0d row=%0d col=%0d",
                       $realtime, want.beep, want.cell_char, want.cell_is_cursor,
                       want.cur_row, want.cur_col, got.beep, got.cell_char,
                       got.cell_is_cursor, got.cur_row, got.cur_col);
          end
        end
      end
      if (in_valid && in_ready) begin
        progress = 1'b1;
        req_taken = 1'b1;
        want = '0;
        if (in_operation == OP_FEED) begin
          want.beep = term_feed(in_data_byte);
        end else if (in_read_row < ROWS && in_read_col < COLS) begin
          want.cell_char = screen_mem[in_read_row * COLS + in_read_col];
          want.cell_is_cursor = (in_read_row == scr_row && in_read_col == scr_col);
        end
        want.cur_row = ROW_W'(scr_row);
        want.cur_col = COL_W'(scr_col);
        predicted_resp.push_back(want);
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : stim
    int         r;
    int         n;
    int         k;
    int         next_drain;
    logic [7:0] b;

    for (int i = 0; i < CELLS; i++) screen_mem[i] = BLANK;

    // directed: field extremes, every control, parser corners
    add_read(0, 0);
    add_read(31, 127);
    add_read(ROWS - 1, COLS - 1);
    add_feed(8'h00);
    add_feed(CH_BEL);
    add_feed(CH_DEL - 8'd1);
    add_feed(CH_DEL);
    add_feed(8'hFF);
    add_feed(CH_TAB);
    add_feed(CH_BS);
    add_feed(CH_CR);
    add_feed(CH_LF);
    add_feed(CH_ESC);
    add_feed(CH_HOME);                 // ESC without '[' drops this byte
    add_feed(CH_ESC);
    add_feed(CH_LBRK);
    repeat (3) add_feed(CH_NINE);      // argument saturates
    add_feed(CH_RIGHT);
    add_feed(CH_DEL - 8'd1);           // last column, wraps
    add_feed(CH_ESC);
    add_feed(CH_LBRK);
    add_feed(CH_ED);
    add_cursor_read();

    // random: mostly well-formed text, controls and escape sequences
    drain_next = 1'b1;
    next_drain = pending_reqs.size() + DRAIN_EVERY;
    while (pending_reqs.size() < STIM_ITEMS) begin
      if (pending_reqs.size() >= next_drain) begin
        drain_next = 1'b1;
        next_drain += DRAIN_EVERY;
      end
      r = $urandom_range(0, 99);
      if (r < 35) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 8);
        repeat (n) add_feed(8'($urandom_range(CH_SPACE, CH_DEL - 8'd1)));
      end else if (r < 45) begin
        k = $urandom_range(0, 5);
        case (k)
          0: b = CH_BEL;
          1: b = CH_BS;
          2: b = CH_TAB;
          3: b = CH_LF;
          4: b = CH_CR;
          default: b = 8'($urandom_range(0, CH_SPACE - 8'd1));
        endcase
        add_feed(b);
      end else if (r < 75) begin
        add_feed(CH_ESC);
        add_feed(CH_LBRK);
        n = $urandom_range(0, 3);
        for (k = 0; k < n; k++) begin
          if (k > 0) add_feed(CH_SEMI);
          r = $urandom_range(0, 99);
          repeat ((r < 15) ? 0 : (r < 70) ? 1 : (r < 90) ? 2 : 3)
            add_feed(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        r = $urandom_range(0, 99);
        if (r < 14)      b = CH_UP;
        else if (r < 28) b = CH_DOWN;
        else if (r < 42) b = CH_RIGHT;
        else if (r < 56) b = CH_LEFT;
        else if (r < 74) b = CH_HOME;
        else if (r < 80) b = CH_ED;
        else if (r < 90) b = CH_EL;
        else begin
          b = 8'($urandom);            // random final byte
          if ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SEMI) b = CH_DEL;
        end
        add_feed(b);
      end else if (r < 88) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 2) == 0) add_cursor_read();
          else add_read($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
        end
      end else if (r < 94) begin
        add_read($urandom_range(0, 31), $urandom_range(0, 127));
      end else begin
        k = $urandom_range(0, 2);
        if (k == 0) begin
          add_feed(8'($urandom));
        end else begin
          add_feed(CH_ESC);
          if (k == 1) begin
            add_feed(8'($urandom));
          end else begin
            add_feed(CH_LBRK);
            repeat ($urandom_range(1, 3)) add_feed(8'($urandom));
          end
        end
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid || predicted_resp.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fault_cnt == 0 && predicted_resp.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
